/* rtl/core/fat_pkg.sv */
// Shared types, codes and constants for the fade and arpeggio ticker.
// No dependencies; every other file in rtl/core imports this package.

package fat_pkg;

    // Defaults for the top-level parameters
    localparam int CHANNELS_DEF   = 4;
    localparam int NOTE_SLOTS_DEF = 16;

    // Fade and arpeggio constants
    localparam int         FADE_STRIDE_BITS = 3;       // volume update every 8th step
    localparam logic [7:0] END_VOLUME       = 8'd1;
    localparam int         RESULT_CAP       = 8;       // results per input word
    localparam int         CNT_W            = 4;       // holds 0..RESULT_CAP
    localparam logic [8:0] TICK_MAX         = 9'd511;

    // Shared divider geometry: 8 quotient bits, 16-bit divisor
    localparam int DIV_NUM_W = 8;
    localparam int DIV_REM_W = 16;
    localparam int DIV_STEPS = DIV_NUM_W;

    // Register port geometry
    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    // Register indexes (byte address / 4)
    localparam logic [1:0] REG_PLAY_MODE  = 2'd0;
    localparam logic [1:0] REG_ARP_DELAY  = 2'd1;
    localparam logic [1:0] REG_ARP_COUNT  = 2'd2;

    // Input action codes
    typedef enum logic [2:0] {
        ACT_TICK        = 3'd0,
        ACT_FADE_START  = 3'd1,
        ACT_FADE_RESET  = 3'd2,
        ACT_NOTE_LOAD   = 3'd3,
        ACT_ARP_RESTART = 3'd4
    } action_t;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_VOLUME   = 2'd0,
        KIND_NOTE     = 2'd1,
        KIND_FADE_END = 2'd2
    } kind_t;

    // Input word
    typedef struct packed {
        logic [2:0]  action;
        logic [1:0]  channel;
        logic [15:0] fade_length;
        logic [7:0]  start_volume;
        logic [3:0]  note_index;
        logic [7:0]  note_value;
    } cmd_t;

    // Result word
    typedef struct packed {
        logic [1:0] kind;
        logic [1:0] out_channel;
        logic [7:0] out_value;
        logic       last;
    } rsp_t;

    // Configuration register contents
    typedef struct packed {
        logic       play_mode;
        logic [7:0] arp_step_delay;
        logic [4:0] arp_note_count;
    } cfg_t;

    // Divider request and response
    typedef struct packed {
        logic                 start;
        logic [DIV_REM_W-1:0] rem_init;
        logic [DIV_NUM_W-1:0] num_low;
        logic [DIV_REM_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic                 done;
        logic [DIV_NUM_W-1:0] quotient;
        logic [DIV_REM_W-1:0] remainder;
    } div_rsp_t;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_CHAN,
        S_DSTART,
        S_DWAIT,
        S_VOL,
        S_STEP,
        S_END,
        S_NREAD,
        S_NOTE,
        S_FLUSH
    } seq_state_t;

endpackage

/* rtl/core/fat_cfg_regs.sv */
// APB-style register file: play mode, arpeggio step delay, arpeggio note count.
// Depends on fat_pkg.

module fat_cfg_regs
    import fat_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    logic       play_mode_reg;
    logic [7:0] arp_delay_reg;
    logic [4:0] arp_count_reg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            play_mode_reg <= 1'b0;
            arp_delay_reg <= 8'd0;
            arp_count_reg <= 5'd1;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_PLAY_MODE: play_mode_reg <= pwdata[0];
                REG_ARP_DELAY: arp_delay_reg <= pwdata[7:0];
                REG_ARP_COUNT: arp_count_reg <= pwdata[4:0];
                default:       ;
            endcase
        end
    end

    // Read mux
    always_comb
    begin
        unique case (reg_idx)
            REG_PLAY_MODE: prdata = {31'd0, play_mode_reg};
            REG_ARP_DELAY: prdata = {24'd0, arp_delay_reg};
            REG_ARP_COUNT: prdata = {27'd0, arp_count_reg};
            default:       prdata = '0;
        endcase
    end

    assign cfg.play_mode      = play_mode_reg;
    assign cfg.arp_step_delay = arp_delay_reg;
    assign cfg.arp_note_count = arp_count_reg;

endmodule

/* rtl/core/fat_divider.sv */
// Shared restoring divider: one quotient bit per cycle, DIV_STEPS quotient bits per run.
// Needs rem_init < divisor. Depends on fat_pkg.

module fat_divider
    import fat_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam int SW = $clog2(DIV_STEPS);

    logic                 busy_reg;
    logic                 done_reg;
    logic [SW-1:0]        step_reg;
    logic [DIV_REM_W-1:0] rem_reg;
    logic [DIV_NUM_W-1:0] num_reg;     // dividend bits out, quotient bits in
    logic [DIV_REM_W-1:0] dvsr_reg;

    logic [DIV_REM_W:0]   trial;
    logic                 fits;
    logic [DIV_REM_W-1:0] rem_next;
    logic [DIV_NUM_W-1:0] num_next;

    // One restoring step
    always_comb
    begin
        trial    = {rem_reg, num_reg[DIV_NUM_W-1]};
        fits     = (trial >= {1'b0, dvsr_reg});
        rem_next = fits ? DIV_REM_W'(trial - {1'b0, dvsr_reg}) : trial[DIV_REM_W-1:0];
        num_next = {num_reg[DIV_NUM_W-2:0], fits};
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + SW'(1);
                if (step_reg == SW'(DIV_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg  <= req.rem_init;
            num_reg  <= req.num_low;
            dvsr_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            num_reg <= num_next;
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = num_reg;
    assign rsp.remainder = rem_reg;

endmodule

/* rtl/core/fat_note_mem.sv */
// Arpeggio note table: one write port, one registered read port.
// Contents undefined until written. Depends on fat_pkg.

module fat_note_mem
    import fat_pkg::*;
#(
    parameter int NOTE_SLOTS = NOTE_SLOTS_DEF
)
(
    input  logic                          clk,
    input  logic                          we,
    input  logic [$clog2(NOTE_SLOTS)-1:0] waddr,
    input  logic [7:0]                    wdata,
    input  logic [$clog2(NOTE_SLOTS)-1:0] raddr,
    output logic [7:0]                    rdata
);

    logic [7:0] mem [NOTE_SLOTS];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/fat_seq.sv */
// Sequencer: fade channel state, arpeggio cursor and tick counter, result
// staging and the output register. Drives the shared divider and note table.
// Depends on fat_pkg.

module fat_seq
    import fat_pkg::*;
#(
    parameter int CHANNELS   = CHANNELS_DEF,
    parameter int NOTE_SLOTS = NOTE_SLOTS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  cfg_t                          cfg,
    input  logic                          cmd_valid,
    output logic                          cmd_stall,
    input  cmd_t                          cmd,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output rsp_t                          rsp,
    output div_req_t                      div_req,
    input  div_rsp_t                      div_rsp,
    output logic                          mem_we,
    output logic [$clog2(NOTE_SLOTS)-1:0] mem_waddr,
    output logic [7:0]                    mem_wdata,
    output logic [$clog2(NOTE_SLOTS)-1:0] mem_raddr,
    input  logic [7:0]                    mem_rdata
);

    localparam int IW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int PW = $clog2(NOTE_SLOTS);

    // Per-channel fade state
    logic        active_reg [CHANNELS];
    logic [7:0]  base_reg   [CHANNELS];
    logic [15:0] span_reg   [CHANNELS];
    logic [16:0] pos_reg    [CHANNELS];

    // Arpeggio state
    logic [PW-1:0] arp_pos_reg;
    logic [8:0]    tick_reg;

    // Sequencer state and working registers
    seq_state_t     state_reg, state_next;
    logic [IW-1:0]  idx_reg;
    logic           arp_op_reg;
    logic [23:0]    prod_reg;
    logic [7:0]     vol_reg;
    logic [CNT_W-1:0] count_reg;

    // Result staging: one pending word, one output word
    rsp_t pend_reg;
    logic pend_valid_reg;
    rsp_t out_reg;
    logic out_valid_reg;

    // Decoded signals
    logic          cmd_acc;
    logic          ch_ok;
    logic [IW-1:0] cmd_ch;
    logic          cur_active;
    logic [7:0]    cur_base;
    logic [15:0]   cur_span;
    logic [16:0]   cur_pos;
    logic [16:0]   pos_inc;
    logic          fade_done;
    logic          chan_last;
    logic [7:0]    cnt_eff;
    logic [8:0]    delay9;
    logic          arp_fire;
    logic [8:0]    tick_after;
    logic [8:0]    tick_next;
    logic          out_free;
    logic          push_req;
    logic          push_drop;
    logic          push_go;
    logic          flush_go;
    rsp_t          push_word;

    assign cmd_acc   = cmd_valid && (state_reg == S_IDLE);
    assign cmd_stall = (state_reg != S_IDLE);
    assign cmd_ch    = IW'(cmd.channel);
    assign ch_ok     = (32'(cmd.channel) < 32'(CHANNELS));

    // Current channel view
    assign cur_active = active_reg[idx_reg];
    assign cur_base   = base_reg[idx_reg];
    assign cur_span   = span_reg[idx_reg];
    assign cur_pos    = pos_reg[idx_reg];
    assign pos_inc    = cur_pos + 17'd1;
    assign fade_done  = (pos_inc > {1'b0, cur_span});
    assign chan_last  = (idx_reg == IW'(CHANNELS - 1));

    // Effective note count: zero acts as one, capped at the table size
    always_comb
    begin
        priority if (cfg.arp_note_count == 5'd0)
            cnt_eff = 8'd1;
        else if (8'(cfg.arp_note_count) > 8'(NOTE_SLOTS))
            cnt_eff = 8'(NOTE_SLOTS);
        else
            cnt_eff = 8'(cfg.arp_note_count);
    end

    // Arpeggio tick counter: step when past the delay, then count with saturation
    assign delay9     = 9'(cfg.arp_step_delay);
    assign arp_fire   = (tick_reg > delay9);
    assign tick_after = arp_fire ? (tick_reg - delay9) : tick_reg;
    assign tick_next  = (tick_after < TICK_MAX) ? (tick_after + 9'd1) : tick_after;

    // Result handshake helpers
    assign out_free  = !out_valid_reg || !rsp_stall;
    assign push_drop = (count_reg == CNT_W'(RESULT_CAP));
    assign push_go   = push_req && (push_drop || !pend_valid_reg || out_free);
    assign flush_go  = (state_reg == S_FLUSH) && (!pend_valid_reg || out_free);

    // Divider operands
    always_comb
    begin
        div_req.start = (state_reg == S_DSTART);
        if (arp_op_reg)
        begin
            div_req.rem_init = '0;
            div_req.num_low  = 8'(arp_pos_reg) + 8'd1;
            div_req.divisor  = {8'd0, cnt_eff};
        end
        else
        begin
            // position never exceeds span, so the quotient fits 8 bits
            div_req.rem_init = prod_reg[23:8];
            div_req.num_low  = prod_reg[7:0];
            div_req.divisor  = cur_span;
        end
    end

    // Note table ports
    assign mem_we    = cmd_acc && (cmd.action == ACT_NOTE_LOAD)
                       && (32'(cmd.note_index) < 32'(NOTE_SLOTS));
    assign mem_waddr = PW'(cmd.note_index);
    assign mem_wdata = cmd.note_value;
    assign mem_raddr = arp_pos_reg;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and result requests
    always_comb
    begin
        state_next           = state_reg;
        push_req             = 1'b0;
        push_word.kind       = KIND_VOLUME;
        push_word.out_channel = 2'(idx_reg);
        push_word.out_value  = vol_reg;
        push_word.last       = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_acc)
                begin
                    if (cmd.action == ACT_TICK)
                    begin
                        if (!cfg.play_mode)
                            state_next = S_CHAN;
                        else if (arp_fire)
                            state_next = S_DSTART;
                    end
                    else if (cmd.action == ACT_ARP_RESTART)
                    begin
                        state_next = S_NREAD;
                    end
                end
            end
            S_CHAN:
            begin
                priority if (!cur_active)
                    state_next = chan_last ? S_FLUSH : S_CHAN;
                else if (cur_pos[FADE_STRIDE_BITS-1:0] == '0)
                    state_next = (cur_span != 16'd0) ? S_DSTART : S_VOL;
                else
                    state_next = S_STEP;
            end
            S_DSTART:
            begin
                state_next = S_DWAIT;
            end
            S_DWAIT:
            begin
                if (div_rsp.done)
                    state_next = arp_op_reg ? S_NREAD : S_VOL;
            end
            S_VOL:
            begin
                push_req = 1'b1;
                if (push_go)
                    state_next = S_STEP;
            end
            S_STEP:
            begin
                if (fade_done)
                    state_next = S_END;
                else
                    state_next = chan_last ? S_FLUSH : S_CHAN;
            end
            S_END:
            begin
                push_req            = 1'b1;
                push_word.kind      = KIND_FADE_END;
                push_word.out_value = END_VOLUME;
                if (push_go)
                    state_next = chan_last ? S_FLUSH : S_CHAN;
            end
            S_NREAD:
            begin
                state_next = S_NOTE;
            end
            S_NOTE:
            begin
                push_req              = 1'b1;
                push_word.kind        = KIND_NOTE;
                push_word.out_channel = 2'd0;
                push_word.out_value   = mem_rdata;
                if (push_go)
                    state_next = S_FLUSH;
            end
            S_FLUSH:
            begin
                if (flush_go)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Fade channel state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                active_reg[i] <= 1'b0;
                base_reg[i]   <= 8'd0;
                span_reg[i]   <= 16'd0;
                pos_reg[i]    <= 17'd0;
            end
        end
        else if (cmd_acc && ch_ok && (cmd.action == ACT_FADE_START))
        begin
            active_reg[cmd_ch] <= 1'b1;
            base_reg[cmd_ch]   <= cmd.start_volume;
            span_reg[cmd_ch]   <= cmd.fade_length;
            pos_reg[cmd_ch]    <= 17'd0;
        end
        else if (cmd_acc && ch_ok && (cmd.action == ACT_FADE_RESET))
        begin
            active_reg[cmd_ch] <= 1'b0;
            base_reg[cmd_ch]   <= 8'd0;
            span_reg[cmd_ch]   <= 16'd0;
            pos_reg[cmd_ch]    <= 17'd0;
        end
        else if (state_reg == S_STEP)
        begin
            if (fade_done)
            begin
                active_reg[idx_reg] <= 1'b0;
                base_reg[idx_reg]   <= 8'd0;
                span_reg[idx_reg]   <= 16'd0;
                pos_reg[idx_reg]    <= 17'd0;
            end
            else
            begin
                pos_reg[idx_reg] <= pos_inc;
            end
        end
    end

    // Arpeggio cursor and tick counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            arp_pos_reg <= '0;
            tick_reg    <= 9'd0;
        end
        else
        begin
            if (cmd_acc && (cmd.action == ACT_TICK) && cfg.play_mode)
                tick_reg <= tick_next;
            if ((state_reg == S_DWAIT) && div_rsp.done && arp_op_reg)
                arp_pos_reg <= PW'(div_rsp.remainder);
        end
    end

    // Working registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg    <= '0;
            arp_op_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            if (cmd_acc)
            begin
                idx_reg    <= '0;
                arp_op_reg <= cfg.play_mode;
                count_reg  <= '0;
            end
            else
            begin
                if (push_go && !push_drop)
                    count_reg <= count_reg + CNT_W'(1);
                // move to the next channel
                if (((state_reg == S_CHAN) && !cur_active)
                    || ((state_reg == S_STEP) && !fade_done)
                    || ((state_reg == S_END) && push_go))
                    idx_reg <= idx_reg + IW'(1);
            end
        end
    end

    // Product and volume
    always_ff @(posedge clk)
    begin
        if (state_reg == S_CHAN)
        begin
            prod_reg <= cur_base * cur_pos[15:0];
            vol_reg  <= 8'd0;
        end
        else if ((state_reg == S_DWAIT) && div_rsp.done)
        begin
            vol_reg <= cur_base - div_rsp.quotient;
        end
    end

    // Pending and output words
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (push_go && !push_drop)
            begin
                pend_valid_reg <= 1'b1;
                if (pend_valid_reg)
                    out_valid_reg <= 1'b1;
                else if (out_valid_reg && !rsp_stall)
                    out_valid_reg <= 1'b0;
            end
            else if (flush_go && pend_valid_reg)
            begin
                pend_valid_reg <= 1'b0;
                out_valid_reg  <= 1'b1;
            end
            else if (out_valid_reg && !rsp_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_go && !push_drop)
        begin
            pend_reg <= push_word;
            if (pend_valid_reg)
            begin
                out_reg      <= pend_reg;
                out_reg.last <= 1'b0;
            end
        end
        else if (flush_go && pend_valid_reg)
        begin
            out_reg      <= pend_reg;
            out_reg.last <= 1'b1;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    // Nothing is left staged once the sequencer is idle
    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !pend_valid_reg)
        else $error("pending word left behind in idle");

    // Result count stays within the cap
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(RESULT_CAP))
        else $error("result count above cap");

    // An active fade never runs past its span
    a_pos_span: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg[idx_reg] |-> (pos_reg[idx_reg] <= {1'b0, span_reg[idx_reg]}))
        else $error("fade position beyond span");

    // Divider finishes only while the sequencer waits for it
    a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == S_DWAIT))
        else $error("divider done outside wait state");

endmodule

/* rtl/core/fade_and_arpeggio_ticker_unit.sv */
// Top level of the fade and arpeggio ticker: register port, sequencer,
// shared divider and note table. Depends on fat_pkg and the fat_* modules.
//
//   port group   dir  handshake             word
//   cmd          in   cmd_valid/cmd_stall   cmd_t: action, channel, fade data, note data
//   rsp          out  rsp_valid/rsp_stall   rsp_t: kind, out_channel, out_value, last
//   apb          in   psel/penable/pready   registers at 0x0, 0x4, 0x8
//
// Start fade, reset fade, load note and unused actions leave the sequencer idle.
// Fade tick: each channel is visited in turn; an active one on the stride gets a
// volume update through the 8-step shared divider, unless its span is zero.
// Arpeggio step tick runs the divider, then reads the note; restart only reads it.
// Reset clears fade state, cursor and tick counter; the note table is undefined
// until loaded. A stalled output holds the sequencer at its next result.

module fade_and_arpeggio_ticker_unit
    import fat_pkg::*;
#(
    parameter int CHANNELS   = CHANNELS_DEF,
    parameter int NOTE_SLOTS = NOTE_SLOTS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_stall,
    input  cmd_t              cmd,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output rsp_t              rsp,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    localparam int PW = $clog2(NOTE_SLOTS);

    cfg_t          cfg;
    div_req_t      div_req;
    div_rsp_t      div_rsp;
    logic          mem_we;
    logic [PW-1:0] mem_waddr;
    logic [7:0]    mem_wdata;
    logic [PW-1:0] mem_raddr;
    logic [7:0]    mem_rdata;

    // Configuration registers
    fat_cfg_regs u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Shared divider
    fat_divider u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Note table
    fat_note_mem #(
        .NOTE_SLOTS (NOTE_SLOTS)
    ) u_notes
    (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Sequencer
    fat_seq #(
        .CHANNELS   (CHANNELS),
        .NOTE_SLOTS (NOTE_SLOTS)
    ) u_seq
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .div_req   (div_req),
        .div_rsp   (div_rsp),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

endmodule

/* sim/fat_checker.sv */
// Scoreboard for the fade and arpeggio ticker: watches the command, result and
// register ports, predicts every result word and compares. Depends on fat_pkg.

module fat_checker
    import fat_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    input  logic              cmd_stall,
    input  cmd_t              cmd,
    input  logic              rsp_valid,
    input  logic              rsp_stall,
    input  rsp_t              rsp,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    input  logic [APB_DW-1:0] prdata,
    input  logic              pready,
    output int                error_count,
    output int                words_due
);
    timeunit 1ns;
    timeprecision 1ps;

    // Register copies
    logic       play_mode;
    logic [7:0] step_delay;
    logic [4:0] note_count;

    // Channel fade state
    logic        fading    [CHANNELS_DEF];
    logic [7:0]  base_vol  [CHANNELS_DEF];
    logic [15:0] span      [CHANNELS_DEF];
    logic [16:0] position  [CHANNELS_DEF];

    // Arpeggio state
    logic [7:0] notes [NOTE_SLOTS_DEF];
    logic [3:0] cursor;
    logic [8:0] tick_count;

    // Words owed by the block, oldest first; batch collects one command's words
    rsp_t sound_due [$];
    rsp_t batch [$];
    rsp_t want;
    logic [APB_DW-1:0] reg_now;

    // Queue one result word, dropping any beyond the per-command cap
    function automatic void add_word(kind_t k, logic [1:0] ch, logic [7:0] v);
        rsp_t w;
        if (batch.size() >= RESULT_CAP)
            return;
        w.kind        = k;
        w.out_channel = ch;
        w.out_value   = v;
        w.last        = 1'b0;
        batch.push_back(w);
    endfunction

    function automatic void stop_fade(int ch);
        fading[ch]   = 1'b0;
        base_vol[ch] = '0;
        span[ch]     = '0;
        position[ch] = '0;
    endfunction

    // Apply one command to the channel and arpeggio state, queue its words
    task automatic run_sound_command(input cmd_t c);
        int unsigned b;
        int unsigned vol;
        int unsigned used;
        batch.delete();
        case (c.action)
            ACT_TICK:
                if (!play_mode) begin
                    for (int ch = 0; ch < CHANNELS_DEF; ch++)
                    begin
                        if (!fading[ch])
                            continue;
                        // volume update on every eighth step
                        if (position[ch][FADE_STRIDE_BITS-1:0] == '0) begin
                            vol = 0;
                            if (span[ch] != 0) begin
                                b   = base_vol[ch];
                                vol = b - (b * position[ch]) / span[ch];
                            end
                            add_word(KIND_VOLUME, 2'(ch), 8'(vol));
                        end
                        position[ch] = position[ch] + 17'd1;
                        if (position[ch] > {1'b0, span[ch]}) begin
                            stop_fade(ch);
                            add_word(KIND_FADE_END, 2'(ch), END_VOLUME);
                        end
                    end
                end
                else begin
                    if (tick_count > {1'b0, step_delay}) begin
                        tick_count = tick_count - {1'b0, step_delay};
                        // zero count acts as one, oversize as the table size
                        used = note_count;
                        if (used == 0)
                            used = 1;
                        if (used > NOTE_SLOTS_DEF)
                            used = NOTE_SLOTS_DEF;
                        cursor = 4'((int'(cursor) + 1) % used);
                        add_word(KIND_NOTE, 2'd0, notes[cursor]);
                    end
                    if (tick_count < TICK_MAX)
                        tick_count = tick_count + 9'd1;
                end
            ACT_FADE_START:
            begin
                fading[c.channel]   = 1'b1;
                base_vol[c.channel] = c.start_volume;
                span[c.channel]     = c.fade_length;
                position[c.channel] = '0;
            end
            ACT_FADE_RESET:
                stop_fade(c.channel);
            ACT_NOTE_LOAD:
                notes[c.note_index] = c.note_value;
            ACT_ARP_RESTART:
                add_word(KIND_NOTE, 2'd0, notes[cursor]);
            default:
                ;
        endcase
        if (batch.size() > 0)
            batch[batch.size()-1].last = 1'b1;
        foreach (batch[k])
            sound_due.push_back(batch[k]);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            play_mode  = 1'b0;
            step_delay = '0;
            note_count = 5'd1;
            for (int ch = 0; ch < CHANNELS_DEF; ch++)
                stop_fade(ch);
            foreach (notes[k])
                notes[k] = '0;
            cursor     = '0;
            tick_count = '0;
            sound_due.delete();
            words_due  = 0;
        end
        else begin
            // Register port: writes update the copy, reads are checked
            if (psel && penable && pready) begin
                if (pwrite) begin
                    case (paddr[APB_AW-1:2])
                        REG_PLAY_MODE: play_mode  = pwdata[0];
                        REG_ARP_DELAY: step_delay = pwdata[7:0];
                        REG_ARP_COUNT: note_count = pwdata[4:0];
                        default:       ;
                    endcase
                end
                else begin
                    case (paddr[APB_AW-1:2])
                        REG_PLAY_MODE: reg_now = APB_DW'(play_mode);
                        REG_ARP_DELAY: reg_now = APB_DW'(step_delay);
                        REG_ARP_COUNT: reg_now = APB_DW'(note_count);
                        default:       reg_now = prdata;
                    endcase
                    if (prdata !== reg_now) begin
                        $error("prdata at 0x%0h: expected 0x%0h, got 0x%0h",
                               paddr, reg_now, prdata);
                        error_count++;
                    end
                end
            end

            // Command words first: a result in the same edge is never older
            if (cmd_valid && !cmd_stall)
                run_sound_command(cmd);

            // Result words against the oldest prediction
            if (rsp_valid && !rsp_stall) begin
                if (sound_due.size() == 0) begin
                    $error("result word with none expected: kind %0d channel %0d value %0d last %0d",
                           rsp.kind, rsp.out_channel, rsp.out_value, rsp.last);
                    error_count++;
                end
                else begin
                    want = sound_due.pop_front();
                    if (rsp.kind !== want.kind) begin
                        $error("kind: expected %0d, got %0d", want.kind, rsp.kind);
                        error_count++;
                    end
                    if (rsp.out_channel !== want.out_channel) begin
                        $error("out_channel: expected %0d, got %0d",
                               want.out_channel, rsp.out_channel);
                        error_count++;
                    end
                    if (rsp.out_value !== want.out_value) begin
                        $error("out_value: expected %0d, got %0d",
                               want.out_value, rsp.out_value);
                        error_count++;
                    end
                    if (rsp.last !== want.last) begin
                        $error("last: expected %0d, got %0d", want.last, rsp.last);
                        error_count++;
                    end
                end
            end
            words_due = sound_due.size();
        end
    end

endmodule

/* sim/testbench.sv */
// Top of the fade and arpeggio ticker bench: clock, reset, command and register
// stimulus, watchdog and verdict. Depends on fat_pkg, the ticker RTL and fat_checker.

module testbench;
    import fat_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          IDLE_PCT     = 28;
    localparam int          STALL_LIMIT  = 3000;   // cycles with no word moving
    localparam int          DRAIN_CYCLES = 120;
    localparam logic [2:0]  SPARE_ACTION = 3'(ACT_ARP_RESTART) + 3'd1;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              cmd_valid;
    logic              cmd_stall;
    cmd_t              cmd;
    logic              rsp_valid;
    logic              rsp_stall = 1'b0;
    rsp_t              rsp;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    int error_count;
    int words_due;
    int quiet_cycles = 0;
    bit steady = 1'b0;    // no idling on either side while set

    fade_and_arpeggio_ticker_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    fat_checker u_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_stall   (cmd_stall),
        .cmd         (cmd),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .rsp         (rsp),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .error_count (error_count),
        .words_due   (words_due)
    );

    always #6 clk = ~clk;

    // Result side stalls at random
    always @(negedge clk)
        rsp_stall <= steady ? 1'b0 : ($urandom_range(0, 99) < IDLE_PCT);

    // Watchdog: too long with no word moving on either channel
    always @(posedge clk)
    begin
        if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic cmd_t word_of(action_t act, logic [1:0] ch, logic [15:0] len,
                                     logic [7:0] vol, logic [3:0] idx, logic [7:0] val);
        cmd_t w;
        w.action       = act;
        w.channel      = ch;
        w.fade_length  = len;
        w.start_volume = vol;
        w.note_index   = idx;
        w.note_value   = val;
        return w;
    endfunction

    // Random command word; fade lengths mostly short so fades run to their end
    function automatic cmd_t random_word(input bit arp);
        cmd_t        w;
        int unsigned roll;
        w.channel      = 2'($urandom);
        w.fade_length  = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                     : 16'($urandom_range(0, 12));
        w.start_volume = 8'($urandom);
        w.note_index   = 4'($urandom);
        w.note_value   = 8'($urandom);
        w.action       = 3'($urandom_range(int'(SPARE_ACTION), (1 << $bits(w.action)) - 1));
        roll = $urandom_range(0, 99);
        if (arp) begin
            if (roll < 55)      w.action = ACT_TICK;
            else if (roll < 70) w.action = ACT_ARP_RESTART;
            else if (roll < 80) w.action = ACT_NOTE_LOAD;
            else if (roll < 85) w.action = ACT_FADE_START;
            else if (roll < 90) w.action = ACT_FADE_RESET;
        end
        else begin
            if (roll < 50)      w.action = ACT_TICK;
            else if (roll < 70) w.action = ACT_FADE_START;
            else if (roll < 77) w.action = ACT_FADE_RESET;
            else if (roll < 83) w.action = ACT_NOTE_LOAD;
            else if (roll < 92) w.action = ACT_ARP_RESTART;
        end
        return w;
    endfunction

    // Send one command word; called and returns at a falling edge
    task automatic send_word(input cmd_t w);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            cmd_valid <= 1'b0;
            @(negedge clk);
        end
        cmd       <= w;
        cmd_valid <= 1'b1;
        do
            @(posedge clk);
        while (cmd_stall);
        @(negedge clk);
    endtask

    // One register access: setup cycle, then access cycle until pready
    task automatic reg_access(input bit wr, input logic [1:0] idx,
                              input logic [APB_DW-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= APB_AW'({idx, 2'b00});
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Stop sending, wait for every owed word, then let the block go quiet
    task automatic settle();
        cmd_valid <= 1'b0;
        while (words_due != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic set_registers(input logic mode, input logic [7:0] delay,
                                 input logic [4:0] count);
        settle();
        reg_access(1'b1, REG_PLAY_MODE, APB_DW'(mode));
        reg_access(1'b1, REG_ARP_DELAY, APB_DW'(delay));
        reg_access(1'b1, REG_ARP_COUNT, APB_DW'(count));
        reg_access(1'b0, REG_PLAY_MODE, '0);
        reg_access(1'b0, REG_ARP_DELAY, '0);
        reg_access(1'b0, REG_ARP_COUNT, '0);
    endtask

    // A random phase under one register setting, with a full drain halfway
    task automatic run_phase(input logic mode, input logic [7:0] delay,
                             input logic [4:0] count, input int words,
                             input bit ticks_only, input bit calm);
        set_registers(mode, delay, count);
        steady = calm;
        for (int k = 0; k < words; k++)
        begin
            if (k == words / 2)
                settle();
            send_word(ticks_only ? word_of(ACT_TICK, 2'($urandom), 16'($urandom),
                                           8'($urandom), 4'($urandom), 8'($urandom))
                                 : random_word(mode));
        end
        steady = 1'b0;
    endtask

    initial
    begin
        rst_n     = 1'b0;
        cmd_valid = 1'b0;
        cmd       = '0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset values of the registers
        reg_access(1'b0, REG_PLAY_MODE, '0);
        reg_access(1'b0, REG_ARP_DELAY, '0);
        reg_access(1'b0, REG_ARP_COUNT, '0);

        // Fill the whole note table so no unwritten slot is ever read
        for (int i = 0; i < NOTE_SLOTS_DEF; i++)
            send_word(word_of(ACT_NOTE_LOAD, '0, '0, '0, 4'(i),
                              (i == 0) ? 8'h00 : (i == NOTE_SLOTS_DEF - 1) ? 8'hFF
                                                                           : 8'($urandom)));

        // Fade corners: zero span, full span, silent and loud starts
        send_word(word_of(ACT_TICK, '0, '0, '0, '0, '0));
        send_word(word_of(ACT_FADE_START, 2'd0, 16'd0, 8'd255, '0, '0));
        send_word(word_of(ACT_FADE_START, 2'd1, 16'd8, 8'd0, '0, '0));
        send_word(word_of(ACT_FADE_START, 2'd2, 16'd17, 8'd200, '0, '0));
        send_word(word_of(ACT_FADE_START, 2'd3, 16'hFFFF, 8'd255, '0, '0));
        send_word(word_of(ACT_TICK, '0, '0, '0, '0, '0));
        send_word(word_of(ACT_TICK, '0, '0, '0, '0, '0));
        send_word(word_of(ACT_FADE_RESET, 2'd3, '0, '0, '0, '0));
        send_word(word_of(ACT_FADE_RESET, 2'd0, '0, '0, '0, '0));
        send_word(word_of(action_t'(SPARE_ACTION), 2'd3, 16'hFFFF, 8'hFF, 4'hF, 8'hFF));
        send_word(word_of(action_t'(3'h7), 2'd2, 16'h1234, 8'h5A, 4'h9, 8'hA5));
        send_word(word_of(ACT_ARP_RESTART, '0, '0, '0, '0, '0));

        // Arpeggio with a zero note count, then an oversize one
        set_registers(1'b1, 8'd0, 5'd0);
        repeat (3) send_word(word_of(ACT_TICK, '0, '0, '0, '0, '0));
        send_word(word_of(ACT_ARP_RESTART, '0, '0, '0, '0, '0));
        set_registers(1'b1, 8'd1, 5'd31);
        repeat (3) send_word(word_of(ACT_TICK, '0, '0, '0, '0, '0));

        // Random phases over several settings
        run_phase(1'b0, 8'd255, 5'd16, 20, 1'b0, 1'b0);
        run_phase(1'b1, 8'd0, 5'd16, 18, 1'b0, 1'b1);
        run_phase(1'b1, 8'd2, 5'd5, 16, 1'b0, 1'b0);
        run_phase(1'b0, 8'($urandom), 5'($urandom_range(1, 16)), 20, 1'b0, 1'b0);
        run_phase(1'b1, 8'($urandom_range(1, 4)), 5'($urandom_range(17, 31)), 16, 1'b0, 1'b0);
        // Enough ticks at zero delay to pin the tick counter at its ceiling
        run_phase(1'b1, 8'd0, 5'($urandom_range(1, 16)), 520, 1'b1, 1'b0);
        run_phase(1'b1, 8'd255, 5'd1, 20, 1'b0, 1'b0);
        run_phase(1'b0, 8'($urandom), 5'($urandom), 20, 1'b0, 1'b0);

        settle();
        if (error_count == 0 && words_due == 0) begin
            $display("Testbench completed without errors");
        end
        else begin
            if (words_due != 0)
                $error("%0d result words never arrived", words_due);
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
